/* design/varint_length_prefix_deframer_core_assert.svh */
// assertion macros used by the deframer core
`ifndef VARINT_LENGTH_PREFIX_DEFRAMER_CORE_ASSERT_SVH
`define VARINT_LENGTH_PREFIX_DEFRAMER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define VLPD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vlpd: invariant violated");

// consequent holds in the same cycle as the antecedent
`define VLPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlpd: implication violated");

// consequent holds in the cycle after the antecedent
`define VLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlpd: next-cycle implication violated");

`endif

/* design/vlpd_pkg.sv */
`default_nettype none

package vlpd_pkg;

  localparam int ByteW     = 8;
  localparam int WordW     = 64;
  localparam int GroupBits = 7;
  localparam int CountW    = 4;

  // index of the last header group that still fits the word
  localparam logic [CountW-1:0] LastGroup = 4'd9;

  // running deframer state
  typedef struct packed {
    logic                 in_payload;
    logic [CountW-1:0]    group_count;
    logic [WordW-1:0]     length_accum;
    logic [WordW-1:0]     bytes_remaining;
    logic                 at_first_payload;
  } state_t;

  // one result beat
  typedef struct packed {
    logic [ByteW-1:0]     payload_byte;
    logic                 payload_valid;
    logic                 first_of_message;
    logic                 last_of_message;
    logic                 header_done;
    logic [WordW-1:0]     message_length;
    logic                 overflow_error;
  } result_t;

  // place a 7-bit group at its position in the length word
  function automatic logic [WordW-1:0] place_group(input logic [GroupBits-1:0] data,
                                                   input logic [CountW-1:0] idx);
    logic [6:0] shamt;
    logic [WordW-1:0] wide;
    wide  = {{(WordW-GroupBits){1'b0}}, data};
    shamt = 7'(idx) * 7'(GroupBits);
    if (idx <= LastGroup) begin
      place_group = wide << shamt;
    end else begin
      place_group = '0;
    end
  endfunction

endpackage

`default_nettype wire

/* design/vlpd_step.sv */
`default_nettype none

module vlpd_step (
  input  wire logic [vlpd_pkg::ByteW-1:0] in_byte,
  input  vlpd_pkg::state_t                cur,
  output vlpd_pkg::state_t                nxt,
  output vlpd_pkg::result_t               res
);

  logic [vlpd_pkg::WordW-1:0] accum;
  logic [vlpd_pkg::WordW-1:0] remaining_dec;

  // merge the new group into the length gathered so far
  assign accum = cur.length_accum |
                 vlpd_pkg::place_group(in_byte[vlpd_pkg::GroupBits-1:0], cur.group_count);

  // payload countdown, held at zero
  assign remaining_dec = (cur.bytes_remaining != '0) ?
                         cur.bytes_remaining - vlpd_pkg::WordW'(1) : cur.bytes_remaining;

  // one byte of header decode or payload pass-through
  always_comb begin
    nxt = cur;
    res = '0;
    if (cur.in_payload) begin
      res.payload_byte     = in_byte;
      res.payload_valid    = 1'b1;
      res.first_of_message = cur.at_first_payload;
      res.last_of_message  = (cur.bytes_remaining <= vlpd_pkg::WordW'(1));
      nxt.at_first_payload = 1'b0;
      nxt.bytes_remaining  = remaining_dec;
      if (remaining_dec == '0) begin
        nxt.in_payload = 1'b0;
      end
    end else begin
      nxt.length_accum = accum;
      if (!in_byte[vlpd_pkg::ByteW-1]) begin
        // header ends here
        res.header_done    = 1'b1;
        res.message_length = accum;
        if (accum != '0) begin
          nxt.in_payload       = 1'b1;
          nxt.bytes_remaining  = accum;
          nxt.at_first_payload = 1'b1;
        end
        nxt.length_accum = '0;
        nxt.group_count  = '0;
      end else if (cur.group_count >= vlpd_pkg::LastGroup) begin
        // continuation set on the tenth byte: drop the header
        res.overflow_error = 1'b1;
        nxt.length_accum   = '0;
        nxt.group_count    = '0;
      end else begin
        nxt.group_count = cur.group_count + vlpd_pkg::CountW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/varint_length_prefix_deframer_core.sv */
// LEB128 length-prefixed deframer.
// Input channel: one stream byte per beat on in_byte (in_valid / in_ready).
// Result channel: exactly one result beat per input beat, in order
// (out_valid / out_ready): the payload byte with its first/last marks, a
// header-complete flag with the decoded 64-bit length, an overflow flag when
// a header runs past ten bytes, or no flag for other header bytes.
// Each result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while out_ready drains the result; the decode
// state updates in the same cycle that a byte is accepted, so bytes may arrive back to back.
// A single output register holds the result; in_ready is high whenever that
// register is empty or is being drained in the same cycle.
// Stall: while out_ready is low and a result waits, in_ready drops and the
// held result stays unchanged; no beat is lost.
// Reset (rst_n low, synchronous): the decoder expects a new header, the
// length and payload counters clear and no result is pending.
`default_nettype none

module varint_length_prefix_deframer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [vlpd_pkg::ByteW-1:0]    in_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vlpd_pkg::ByteW-1:0]         out_payload_byte,
  output logic                               out_payload_valid,
  output logic                               out_first_of_message,
  output logic                               out_last_of_message,
  output logic                               out_header_done,
  output logic [vlpd_pkg::WordW-1:0]         out_message_length,
  output logic                               out_overflow_error
);

  `include "varint_length_prefix_deframer_core_assert.svh"

  vlpd_pkg::state_t  state_r;
  vlpd_pkg::state_t  state_nxt;
  vlpd_pkg::result_t res_nxt;
  vlpd_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_fire;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // per-byte decode
  vlpd_step u_step (
    .in_byte (in_byte),
    .cur     (state_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_payload_byte     = res_r.payload_byte;
  assign out_payload_valid    = res_r.payload_valid;
  assign out_first_of_message = res_r.first_of_message;
  assign out_last_of_message  = res_r.last_of_message;
  assign out_header_done      = res_r.header_done;
  assign out_message_length   = res_r.message_length;
  assign out_overflow_error   = res_r.overflow_error;

  // checks
  `VLPD_ASSERT_ALWAYS(a_group_bound, clk, rst_n, state_r.group_count <= vlpd_pkg::LastGroup)
  `VLPD_ASSERT_ALWAYS(a_payload_count, clk, rst_n, !state_r.in_payload || (state_r.bytes_remaining != '0))
  `VLPD_ASSERT_IMPLY(a_kind_excl, clk, rst_n, out_valid_r, !(res_r.payload_valid && (res_r.header_done || res_r.overflow_error)) && !(res_r.header_done && res_r.overflow_error))
  `VLPD_ASSERT_IMPLY(a_first_in_payload, clk, rst_n, out_valid_r && (res_r.first_of_message || res_r.last_of_message), res_r.payload_valid)
  `VLPD_ASSERT_NEXT(a_header_resets, clk, rst_n, in_fire && !state_r.in_payload && !in_byte[vlpd_pkg::ByteW-1], state_r.group_count == '0 && state_r.length_accum == '0)

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;

  // cycle limit without any beat on either side
  localparam int StallLimit = 2000;
  // window with no idling on either side
  localparam int QuietFrom  = 900;
  localparam int QuietTo    = 1500;

  typedef struct {
    logic [vlpd_pkg::ByteW-1:0] data;
    bit                         drain_first;
  } stream_beat_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [vlpd_pkg::ByteW-1:0]   in_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [vlpd_pkg::ByteW-1:0]   out_payload_byte;
  logic                         out_payload_valid;
  logic                         out_first_of_message;
  logic                         out_last_of_message;
  logic                         out_header_done;
  logic [vlpd_pkg::WordW-1:0]   out_message_length;
  logic                         out_overflow_error;

  stream_beat_t                 byte_stream[$];
  vlpd_pkg::result_t            expected_results[$];
  vlpd_pkg::state_t             deframer;
  int                           cycle_count = 0;
  int                           idle_cycles = 0;
  int                           mismatches = 0;
  int                           results_checked = 0;
  int                           headers_seen = 0;
  int                           overflows_seen = 0;
  int                           stream_bytes = 0;

  varint_length_prefix_deframer_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_payload_byte     (out_payload_byte),
    .out_payload_valid    (out_payload_valid),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message),
    .out_header_done      (out_header_done),
    .out_message_length   (out_message_length),
    .out_overflow_error   (out_overflow_error)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random idling outside the quiet window
  function automatic bit take_break();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) begin
      return 1'b0;
    end
    return $urandom_range(99) < 14;
  endfunction

  // next result of the deframer for one stream byte, updating its state
  function automatic vlpd_pkg::result_t deframe_byte(input logic [vlpd_pkg::ByteW-1:0] b);
    vlpd_pkg::result_t          r;
    logic [vlpd_pkg::WordW-1:0] group;
    r = '0;
    if (deframer.in_payload) begin
      r.payload_byte     = b;
      r.payload_valid    = 1'b1;
      r.first_of_message = deframer.at_first_payload;
      r.last_of_message  = (deframer.bytes_remaining <= 1);
      deframer.at_first_payload = 1'b0;
      if (deframer.bytes_remaining != 0) begin
        deframer.bytes_remaining = deframer.bytes_remaining - 1;
      end
      if (deframer.bytes_remaining == 0) begin
        deframer.in_payload = 1'b0;
      end
    end else begin
      // bits past the top of the word fall off the shift
      group = {{(vlpd_pkg::WordW-vlpd_pkg::GroupBits){1'b0}}, b[vlpd_pkg::GroupBits-1:0]};
      if (deframer.group_count <= vlpd_pkg::LastGroup) begin
        deframer.length_accum = deframer.length_accum |
                                (group << (int'(deframer.group_count) * vlpd_pkg::GroupBits));
      end
      if (!b[vlpd_pkg::ByteW-1]) begin
        r.header_done    = 1'b1;
        r.message_length = deframer.length_accum;
        if (deframer.length_accum != 0) begin
          deframer.in_payload       = 1'b1;
          deframer.bytes_remaining  = deframer.length_accum;
          deframer.at_first_payload = 1'b1;
        end
        deframer.length_accum = '0;
        deframer.group_count  = '0;
      end else if (deframer.group_count >= vlpd_pkg::LastGroup) begin
        r.overflow_error      = 1'b1;
        deframer.length_accum = '0;
        deframer.group_count  = '0;
      end else begin
        deframer.group_count = deframer.group_count + 1'b1;
      end
    end
    return r;
  endfunction

  // stream building
  task automatic push_byte(input logic [vlpd_pkg::ByteW-1:0] b, input bit drain_first = 1'b0);
    stream_beat_t sb;
    sb.data        = b;
    sb.drain_first = drain_first;
    byte_stream.insert(byte_stream.size(), sb);
    stream_bytes++;
  endtask

  // varint header of len in n bytes; junk above bit 0 of a tenth byte is dropped
  task automatic push_header(input logic [vlpd_pkg::WordW-1:0] len, input int n);
    logic [vlpd_pkg::ByteW-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = {1'b0, 7'(len >> (i * vlpd_pkg::GroupBits))};
      if (i == 9 && !b[0]) begin
        b[6:1] = 6'($urandom_range(63));
      end
      if (i < n - 1) begin
        b[vlpd_pkg::ByteW-1] = 1'b1;
      end
      push_byte(b);
    end
  endtask

  task automatic push_message(input int len, input int pad);
    int groups;
    groups = 1;
    while ((len >> (groups * vlpd_pkg::GroupBits)) != 0) begin
      groups++;
    end
    push_header(64'(len), groups + pad);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(255)));
    end
  endtask

  // runaway header: ten bytes with continuation set
  task automatic push_runaway_header();
    for (int i = 0; i < 10; i++) begin
      push_byte({1'b1, 7'($urandom_range(127))});
    end
  endtask

  // driver: predicts on every accepted beat, then offers the next byte
  always @(posedge clk) begin
    stream_beat_t next_beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
      deframer <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), deframe_byte(in_byte));
      end
      if (!in_valid || in_ready) begin
        if (byte_stream.size() == 0 || take_break() ||
            (byte_stream[0].drain_first && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          next_beat = byte_stream.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_beat.data;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    vlpd_pkg::result_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (exp_r.header_done) headers_seen++;
          if (exp_r.overflow_error) overflows_seen++;
          if (out_payload_byte !== exp_r.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", exp_r.payload_byte, out_payload_byte);
            mismatches++;
          end
          if (out_payload_valid !== exp_r.payload_valid) begin
            $error("payload_valid: expected %0b, got %0b",
                   exp_r.payload_valid, out_payload_valid);
            mismatches++;
          end
          if (out_first_of_message !== exp_r.first_of_message) begin
            $error("first_of_message: expected %0b, got %0b",
                   exp_r.first_of_message, out_first_of_message);
            mismatches++;
          end
          if (out_last_of_message !== exp_r.last_of_message) begin
            $error("last_of_message: expected %0b, got %0b",
                   exp_r.last_of_message, out_last_of_message);
            mismatches++;
          end
          if (out_header_done !== exp_r.header_done) begin
            $error("header_done: expected %0b, got %0b", exp_r.header_done, out_header_done);
            mismatches++;
          end
          if (out_message_length !== exp_r.message_length) begin
            $error("message_length: expected %0h, got %0h",
                   exp_r.message_length, out_message_length);
            mismatches++;
          end
          if (out_overflow_error !== exp_r.overflow_error) begin
            $error("overflow_error: expected %0b, got %0b",
                   exp_r.overflow_error, out_overflow_error);
            mismatches++;
          end
        end
      end
    end
  end

  // cycle count and stall watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("no beat for %0d cycles, %0d results pending",
                 idle_cycles, expected_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    int len;
    int groups_pad;
    bit drained;

    drained = 1'b0;

    // directed: empty, one-byte, padded and dropped-bit headers, overflows
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'h02);
    push_byte(8'hff);
    push_byte(8'h80);
    push_byte(8'h80);
    push_byte(8'h00);
    push_header(64'd0, 10);
    push_header(64'd3, 3);
    push_byte(8'h7f);
    push_byte(8'h55);
    push_byte(8'haa);
    for (int i = 0; i < 10; i++) push_byte(8'h80);
    push_byte(8'h00);
    for (int i = 0; i < 10; i++) push_byte(8'hff);
    push_byte(8'h01);
    push_byte(8'h3c);

    // random: mostly well-formed messages, some runaway headers
    while (stream_bytes < 2000) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_runaway_header();
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(8);
        else if (pick < 92) len = $urandom_range(40, 9);
        else len = $urandom_range(300, 100);
        groups_pad = ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
        push_message(len, groups_pad);
      end
      // hold the sender once until everything has come out
      if (!drained && stream_bytes >= 1000) begin
        push_byte(8'h00, 1'b1);
        drained = 1'b1;
      end
    end

    // all-ones length in a full ten-byte header, left open at the end
    for (int i = 0; i < 9; i++) push_byte(8'hff);
    push_byte(8'h01);
    for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(255)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // check between edges so that the driver's updates have settled
    while (byte_stream.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (5) @(posedge clk);

    $display("checked %0d result beats from %0d stream bytes", results_checked, stream_bytes);
    $display("headers completed %0d, runaway headers %0d", headers_seen, overflows_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/vlpd_pkg.sv
design/vlpd_step.sv
design/varint_length_prefix_deframer_core.sv
sim/tb_top.sv
